// ===== hw/rtl/cwfc_pkg.sv =====
// cwfc_pkg: shared types and constants for the cullen/woodall factor check
// no dependencies
package cwfc_pkg;

  localparam int unsigned NBits = 30;
  localparam int unsigned WordW = 64;
  localparam int unsigned CntW  = $clog2(NBits);

  typedef enum logic [2:0] {
    StIdle,
    StRedB,
    StRedN,
    StSquare,
    StMulB,
    StMulN,
    StDone
  } state_e;

  // request to the shared modular multiplier
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } mul_req_t;

  // status back from the shared modular multiplier
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== hw/rtl/cullen_woodall_factor_check_unit.sv =====
// cullen_woodall_factor_check_unit: n*b^n mod p with divisibility flag
// each product runs on the single bit-serial modular multiplier, which sets the rate
// base and n are reduced mod p as 1*x on the same unit
// one item at a time; next item accepted in the cycle after the result is taken
// rst_ni async low: state idle, base register 2, output empty
module cullen_woodall_factor_check_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // factor[63:0], exponent_n[93:64], zero fill
  input  logic         s_axis_tuser,   // woodall_sign
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // residue
  output logic         m_axis_tuser,   // divides
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [29:0]  cfg_data_i      // base
);

  localparam int unsigned W = cwfc_pkg::WordW;

  cwfc_pkg::state_e   state_q, state_d;
  logic [29:0]        base_q;
  logic [W-1:0]       p_q, p_d;
  logic [29:0]        n_q, n_d;
  logic               sign_q, sign_d;
  logic [W-1:0]       bm_q, bm_d;
  logic [W-1:0]       nm_q, nm_d;
  logic [W-1:0]       pw_q, pw_d;
  logic [cwfc_pkg::CntW-1:0] bit_q, bit_d;
  logic               ovld_q, ovld_d;
  logic [W-1:0]       ores_q, ores_d;
  logic               odiv_q, odiv_d;
  logic               issued_q, issued_d;
  cwfc_pkg::mul_req_t req;
  cwfc_pkg::mul_rsp_t rsp;
  logic [W-1:0]       one;

  assign one = (p_q == 64'd1) ? '0 : 64'd1;

  cwfc_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (p_q),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 30'd2;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == cwfc_pkg::StIdle) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = ores_q;
  assign m_axis_tuser  = odiv_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    p_d = p_q; n_d = n_q; sign_d = sign_q;
    bm_d = bm_q; nm_d = nm_q; pw_d = pw_q; bit_d = bit_q;
    ovld_d = ovld_q && !m_axis_tready;
    ores_d = ores_q; odiv_d = odiv_q;
    issued_d = issued_q;
    req.start = 1'b0;
    req.a = '0;
    req.b = '0;
    case (state_q)
      cwfc_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          p_d    = s_axis_tdata[63:0];
          n_d    = s_axis_tdata[93:64];
          sign_d = s_axis_tuser;
          issued_d = 1'b0;
          if (s_axis_tdata[63:0] == '0) begin
            state_d = cwfc_pkg::StDone;
            pw_d    = '0;
          end else begin
            state_d = cwfc_pkg::StRedB;
          end
        end
      end
      // b mod p as 1*b, the bits of b shifted in one per cycle
      cwfc_pkg::StRedB: begin
        if (!issued_q) begin
          req.start = 1'b1;
          req.a = one;
          req.b = 64'(base_q);
          issued_d = 1'b1;
        end else if (rsp.done) begin
          bm_d = rsp.prod; issued_d = 1'b0; state_d = cwfc_pkg::StRedN;
        end
      end
      cwfc_pkg::StRedN: begin
        if (!issued_q) begin
          req.start = 1'b1;
          req.a = one;
          req.b = 64'(n_q);
          issued_d = 1'b1;
        end else if (rsp.done) begin
          nm_d = rsp.prod; issued_d = 1'b0; pw_d = one;
          bit_d = cwfc_pkg::CntW'(cwfc_pkg::NBits - 1);
          state_d = cwfc_pkg::StSquare;
        end
      end
      cwfc_pkg::StSquare: begin
        if (!issued_q) begin
          req.start = 1'b1; req.a = pw_q; req.b = pw_q; issued_d = 1'b1;
        end else if (rsp.done) begin
          pw_d = rsp.prod; issued_d = 1'b0;
          if (n_q[bit_q]) state_d = cwfc_pkg::StMulB;
          else if (bit_q == '0) state_d = cwfc_pkg::StMulN;
          else bit_d = bit_q - cwfc_pkg::CntW'(1);
        end
      end
      cwfc_pkg::StMulB: begin
        if (!issued_q) begin
          req.start = 1'b1; req.a = pw_q; req.b = bm_q; issued_d = 1'b1;
        end else if (rsp.done) begin
          pw_d = rsp.prod; issued_d = 1'b0;
          if (bit_q == '0) state_d = cwfc_pkg::StMulN;
          else begin
            bit_d = bit_q - cwfc_pkg::CntW'(1); state_d = cwfc_pkg::StSquare;
          end
        end
      end
      cwfc_pkg::StMulN: begin
        if (!issued_q) begin
          req.start = 1'b1; req.a = pw_q; req.b = nm_q; issued_d = 1'b1;
        end else if (rsp.done) begin
          pw_d = rsp.prod; issued_d = 1'b0; state_d = cwfc_pkg::StDone;
        end
      end
      cwfc_pkg::StDone: begin
        if (!ovld_q) begin
          ovld_d = 1'b1;
          ores_d = pw_q;
          if (p_q == '0) odiv_d = 1'b0;
          else if (sign_q) odiv_d = (pw_q == one);
          else odiv_d = (pw_q == p_q - 64'd1);
          state_d = cwfc_pkg::StIdle;
        end
      end
      default: state_d = cwfc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cwfc_pkg::StIdle;
      ovld_q   <= 1'b0;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovld_q   <= ovld_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; n_q <= n_d; sign_q <= sign_d;
    bm_q <= bm_d; nm_q <= nm_d; pw_q <= pw_d; bit_q <= bit_d;
    ores_q <= ores_d; odiv_q <= odiv_d;
  end

`ifndef ASSERT_OFF
  // no new item while the multiplier is running
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp.busy |-> !s_axis_tready)
    else $error("item accepted while multiply busy");
  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // residue stays below a nonzero factor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && p_q != '0 |-> m_axis_tdata < p_q)
    else $error("residue not reduced");
`endif

endmodule

// ===== hw/rtl/cwfc_modmul.sv =====
// cwfc_modmul: bit-serial (a*b) mod m, one multiplier bit per cycle
// depends on cwfc_pkg; a < m, m >= 1, b any word, so a = 1 gives b mod m
module cwfc_modmul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [cwfc_pkg::WordW-1:0] mod_i,
  input  cwfc_pkg::mul_req_t       req_i,
  output cwfc_pkg::mul_rsp_t       rsp_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [cwfc_pkg::WordW-1:0] acc_q, acc_d;
  logic [cwfc_pkg::WordW-1:0] a_q, a_d;
  logic [cwfc_pkg::WordW-1:0] b_q, b_d;
  logic [6:0]                 cnt_q, cnt_d;

  logic [cwfc_pkg::WordW:0]   dbl, dsum;
  logic [cwfc_pkg::WordW-1:0] acc2;

  // double then conditional add, both reduced by one compare-subtract
  always_comb begin
    dbl  = {acc_q, 1'b0};
    acc2 = (dbl >= {1'b0, mod_i}) ? 64'(dbl - {1'b0, mod_i}) : dbl[cwfc_pkg::WordW-1:0];
    dsum = {1'b0, acc2} + {1'b0, a_q};
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      cnt_d  = 7'd0;
    end else if (busy_q) begin
      if (b_q[cwfc_pkg::WordW-1]) begin
        acc_d = (dsum >= {1'b0, mod_i}) ? 64'(dsum - {1'b0, mod_i}) : dsum[cwfc_pkg::WordW-1:0];
      end else begin
        acc_d = acc2;
      end
      b_d   = {b_q[cwfc_pkg::WordW-2:0], 1'b0};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(cwfc_pkg::WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// ===== tb/cullen_woodall_factor_check_unit_tb.sv =====
// cullen_woodall_factor_check_unit_tb: self-checking bench for the cullen/woodall factor check
// predicts n*b^n mod p and the divides flag per item; depends on cwfc_pkg and the unit
`timescale 1ns / 1ps

module cullen_woodall_factor_check_unit_tb;

  typedef struct packed {
    logic [63:0] residue;
    logic        divides;
  } check_result_t;

  localparam longint unsigned CycleLimit = 64'd30_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [29:0] cfg_data_i;

  logic [29:0]     base_q;
  check_result_t   pending_results[$];
  int              err_cnt;
  bit              src_idle_en;
  bit              sink_idle_en;
  int              sink_hold;
  longint unsigned cyc_cnt;

  cullen_woodall_factor_check_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // factor[63:0], exponent_n[93:64], zero fill
    .s_axis_tuser (s_axis_tuser),   // woodall_sign
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // residue
    .m_axis_tuser (m_axis_tuser),   // divides
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)      // base
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cyc_cnt = 0;
    forever begin
      @(posedge clk_i);
      cyc_cnt++;
      if (cyc_cnt > CycleLimit) begin
        $display("cullen_woodall_factor_check_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // exact (x + y) mod m for x, y < m
  function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  // exact (a * b) mod m by shift and add
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = add_mod(acc, acc, m);
      if (b[i]) acc = add_mod(acc, a, m);
    end
    return acc;
  endfunction

  // expected residue and flag for one item
  function automatic check_result_t factor_check(logic [63:0] p, logic [29:0] n, logic woodall);
    check_result_t res;
    logic [63:0]   b, nm, pw, one;
    res = '0;
    if (p == 0) return res;
    b   = {34'd0, base_q} % p;
    nm  = {34'd0, n} % p;
    one = 64'd1 % p;
    pw  = one;
    for (int i = cwfc_pkg::NBits - 1; i >= 0; i--) begin
      pw = mul_mod(pw, pw, p);
      if (n[i]) pw = mul_mod(pw, b, p);
    end
    res.residue = mul_mod(pw, nm, p);
    res.divides = woodall ? (res.residue == one) : (res.residue == p - 64'd1);
    return res;
  endfunction

  // send one item, predicting at acceptance; valid stays up until the next caller drops it
  task automatic send_item(logic [63:0] p, logic [29:0] n, logic woodall);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, n, p};
    s_axis_tuser  <= woodall;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(factor_check(p, n, woodall));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // write base while idle
  task automatic write_base(logic [29:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    base_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: residue %0h divides %0b", m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        check_result_t exp_res;
        exp_res = pending_results.pop_front();
        if (m_axis_tdata !== exp_res.residue) begin
          $error("residue: expected %0h actual %0h", exp_res.residue, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser !== exp_res.divides) begin
          $error("divides: expected %0b actual %0b", exp_res.divides, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // receiver stalls: random bursts or one long hold
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
      sink_hold = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // extremes of the fields and the special cases
  task automatic test_directed();
    send_item(64'd0, 30'd5, 1'b0);
    send_item(64'd1, 30'd7, 1'b0);
    send_item(64'd1, 30'd7, 1'b1);
    send_item(64'd101, 30'd0, 1'b0);
    send_item(64'd2, 30'd1, 1'b1);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 30'h3FFF_FFFF, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFC5, 30'h3FFF_FFFF, 1'b1);
    // 1*2^1-1 = 1 ... 3*2^3-1=23, 2*2^2+1 = 9 -> 3 divides
    send_item(64'd23, 30'd3, 1'b1);
    send_item(64'd3, 30'd2, 1'b0);
    send_item(64'd9, 30'd2, 1'b0);
    send_item(64'd5, 30'd13, 1'b0);
    send_item(64'd7, 30'd3, 1'b1);
  endtask

  // base extremes, including reduced to zero and one
  task automatic test_base_sweep();
    write_base(30'd0);
    send_item(64'd97, 30'd6, 1'b0);
    send_item(rand_word(), 30'h2AAA_AAAA, 1'b1);
    write_base(30'd1);
    send_item(64'd11, 30'd10, 1'b0);
    send_item(64'd10, 30'd9, 1'b1);
    write_base(30'h3FFF_FFFF);
    send_item(64'h8000_0000_0000_0000, 30'h1555_5555, 1'b0);
    send_item(64'd1_000_000_007, 30'd12345, 1'b1);
    write_base(30'd1_000_000_000);
    send_item(64'd3, 30'd1, 1'b0);
  endtask

  task automatic rand_items(int cnt);
    logic [63:0] p;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 5))
        0:       p = 64'($urandom_range(2, 1000));
        1:       p = {32'd0, $urandom()};
        2:       p = 64'($urandom_range(0, 1));
        default: p = rand_word();
      endcase
      send_item(p, 30'($urandom()), 1'($urandom_range(0, 1)));
    end
  endtask

  // random items over several bases, with idling
  task automatic test_random();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_base(30'($urandom_range(2, 1_000_000_000)));
      rand_items(300);
    end
  endtask

  // long receiver hold while the sender keeps offering, then full drain and a run without idling
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    drain_results();
    @(negedge clk_i);
    sink_hold = 20000;
    rand_items(5);
    drain_results();
    rand_items(270);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    base_q        = 30'd2;
    err_cnt       = 0;
    sink_hold     = 0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_base_sweep();
    test_random();
    test_backpressure();
    drain_results();

    if (err_cnt == 0) begin
      $display("cullen_woodall_factor_check_unit_tb: done, clean");
    end else begin
      $display("cullen_woodall_factor_check_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== cullen_woodall_factor_check_unit.f =====
hw/rtl/cwfc_pkg.sv
hw/rtl/cwfc_modmul.sv
hw/rtl/cullen_woodall_factor_check_unit.sv
tb/cullen_woodall_factor_check_unit_tb.sv
